### hw/rtl/ppwm_pkg.sv
// ----------------------------------------------------------------------------
// ppwm_pkg
// Shared types, constants and helpers for the periodic pattern window
// mismatch minimum unit.
// ----------------------------------------------------------------------------
package ppwm_pkg;

    // history depth and derived widths
    localparam int MAX_WINDOW = 1024;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = 11;
    localparam int SYM_W      = 2;
    localparam int PHASES     = 3;

    localparam logic [CNT_W-1:0] SUM_MAX  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] SEEN_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] WIN_MAX  = CNT_W'(MAX_WINDOW);
    localparam logic [CNT_W-1:0] WIN_MIN  = CNT_W'(1);

    // symbol codes
    localparam logic [SYM_W-1:0] SYM_R = 2'd0;
    localparam logic [SYM_W-1:0] SYM_G = 2'd1;
    localparam logic [SYM_W-1:0] SYM_B = 2'd2;

    // phase codes
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // register indexes
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

    // one symbol on its way from the history stage to the scoring stage
    typedef struct packed {
        logic [PHASES-1:0] bits;     // mismatch per phase, this symbol
        logic [PHASES-1:0] old_bits; // mismatch bits leaving the window
        logic              use_old;  // window already full before this symbol
        logic              full;     // window full after this symbol
        logic              last;     // end of string
    } ppwm_item_t;

    // mismatch bits of a symbol against the three pattern phases
    function automatic logic [PHASES-1:0] mismatch_bits(input logic [SYM_W-1:0] sym,
                                                        input logic [1:0]       phase);
        logic [PHASES-1:0] m;
        case (phase)
            PHASE_0: m = {sym != SYM_B, sym != SYM_G, sym != SYM_R};
            PHASE_1: m = {sym != SYM_R, sym != SYM_B, sym != SYM_G};
            PHASE_2: m = {sym != SYM_G, sym != SYM_R, sym != SYM_B};
            default: m = {PHASES{1'b1}};
        endcase
        return m;
    endfunction

    // window length clamped into the supported range
    function automatic logic [CNT_W-1:0] eff_window(input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] k;
        if (len == '0) begin
            k = WIN_MIN;
        end else if (len > WIN_MAX) begin
            k = WIN_MAX;
        end else begin
            k = len;
        end
        return k;
    endfunction

endpackage

### hw/rtl/periodic_pattern_window_mismatch_min_unit.sv
// ----------------------------------------------------------------------------
// periodic_pattern_window_mismatch_min_unit
// Minimum sliding-window mismatch count of a symbol string against the
// repeating pattern R,G,B in any of its three phases.
// ----------------------------------------------------------------------------
// One symbol is taken per cycle with no gaps. The input stalls only while a
// last symbol is held behind a result that has not been accepted yet. The
// result of a string is registered as follows: the history memory read and
// the input register load when its last symbol is accepted, and the window
// sum update loads the result register once that symbol leaves the input
// register. Throughput is set by the single-port-write, single-port-read
// history memory, which is written and read once per symbol. The window
// length register at byte address 0 may only be changed between strings. A
// string shorter than the window returns zero with the too_short flag in
// tuser set. The history memory needs no clearing after reset.
module periodic_pattern_window_mismatch_min_unit import ppwm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // symbol input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] symbol, rest zero
    input  logic        s_tlast,   // last_symbol
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] min_changes, rest zero
    output logic [0:0]  m_tuser    // [0] too_short
);

    logic [CNT_W-1:0] win_len_reg;
    logic             cfg_wr;
    logic             reg_hit;
    logic             item_valid;
    logic             item_go;
    ppwm_item_t       item;
    logic [CNT_W-1:0] m_min;
    logic             m_short;

    // register access
    assign pready  = 1'b1;
    assign reg_hit = paddr[2] == REG_WINDOW_LENGTH;
    assign cfg_wr  = psel && penable && pwrite && reg_hit;
    assign prdata  = reg_hit ? {{(32-CNT_W){1'b0}}, win_len_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= WIN_MIN;
        end else if (cfg_wr) begin
            win_len_reg <= pwdata[CNT_W-1:0];
        end
    end

    ppwm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .win_len    (win_len_reg),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_sym      (s_tdata[SYM_W-1:0]),
        .s_last     (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_go    (item_go)
    );

    ppwm_score u_score (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_go    (item_go),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_min      (m_min),
        .m_short    (m_short)
    );

    assign m_tdata = {{(16-CNT_W){1'b0}}, m_min};
    assign m_tuser = m_short;

endmodule

### hw/rtl/ppwm_front.sv
// ----------------------------------------------------------------------------
// ppwm_front
// Input stage: phase and length tracking, mismatch history memory and the
// registered read of the bits that leave the window.
// ----------------------------------------------------------------------------
module ppwm_front import ppwm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] win_len,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [SYM_W-1:0] s_sym,
    input  logic             s_last,
    output logic             item_valid,
    output ppwm_item_t       item,
    input  logic             item_go
);

    logic [1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  seen_reg, seen_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic              valid_reg, valid_next;
    logic [PHASES-1:0] bits_reg;
    logic [PHASES-1:0] old_reg;
    logic              use_old_reg, full_reg, last_reg;
    logic [2:0]        hist_mem [MAX_WINDOW];

    logic              s_fire;
    logic [CNT_W-1:0]  k;
    logic [CNT_W-1:0]  count;
    logic [PHASES-1:0] bits;
    logic [ADDR_W-1:0] rd_addr;

    // take a new symbol whenever the held one moves on
    assign s_ready = !valid_reg || item_go;
    assign s_fire  = s_valid && s_ready;

    // per-symbol decode
    always_comb begin
        k       = eff_window(win_len);
        bits    = mismatch_bits(s_sym, phase_reg);
        count   = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + CNT_W'(1);
        rd_addr = wr_ptr_reg - k[ADDR_W-1:0];
    end

    // string position state, cleared after the last symbol
    always_comb begin
        phase_next  = phase_reg;
        seen_next   = seen_reg;
        wr_ptr_next = wr_ptr_reg;
        if (s_fire) begin
            if (s_last) begin
                phase_next  = PHASE_0;
                seen_next   = '0;
                wr_ptr_next = '0;
            end else begin
                phase_next  = (phase_reg == PHASE_2) ? PHASE_0 : phase_reg + 2'd1;
                seen_next   = count;
                wr_ptr_next = wr_ptr_reg + ADDR_W'(1);
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (item_go) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PHASE_0;
            seen_reg   <= '0;
            wr_ptr_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            seen_reg   <= seen_next;
            wr_ptr_reg <= wr_ptr_next;
            valid_reg  <= valid_next;
        end
    end

    // history memory, read-before-write for a full-depth window
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hist_mem[wr_ptr_reg] <= bits;
            old_reg              <= hist_mem[rd_addr];
        end
    end

    // item payload register
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            bits_reg    <= bits;
            use_old_reg <= seen_reg >= k;
            full_reg    <= count >= k;
            last_reg    <= s_last;
        end
    end

    assign item_valid    = valid_reg;
    assign item.bits     = bits_reg;
    assign item.old_bits = old_reg;
    assign item.use_old  = use_old_reg;
    assign item.full     = full_reg;
    assign item.last     = last_reg;

`ifndef SYNTHESIS
    // a last symbol restarts the string position
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_last |=> seen_reg == '0 && phase_reg == PHASE_0 && wr_ptr_reg == '0)
        else $error("string state not cleared after last symbol");

    // phase stays in its three-step cycle
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("phase counter left its cycle");

    // a window that was full stays full after one more symbol
    a_full_order: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && use_old_reg |-> full_reg)
        else $error("window full before but not after symbol");
`endif

endmodule

### hw/rtl/ppwm_score.sv
// ----------------------------------------------------------------------------
// ppwm_score
// Scoring stage: per-phase window sums, running minimum and the result
// register.
// ----------------------------------------------------------------------------
module ppwm_score import ppwm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  ppwm_item_t       item,
    output logic             item_go,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CNT_W-1:0] m_min,
    output logic             m_short
);

    logic [CNT_W-1:0] sums_reg [PHASES];
    logic [CNT_W-1:0] sums_next [PHASES];
    logic [CNT_W-1:0] best_reg, best_next;
    logic             m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] m_min_reg;
    logic             m_short_reg;

    logic [CNT_W-1:0] sums_upd [PHASES];
    logic [CNT_W-1:0] best_upd;
    logic             proc;

    // a symbol without a result never waits on the output
    assign item_go = !item.last || !m_valid_reg || m_ready;
    assign proc    = item_valid && item_go;

    // saturating window sums and the folded minimum
    always_comb begin
        logic [CNT_W-1:0] s;
        best_upd = best_reg;
        for (int p = 0; p < PHASES; p++) begin
            s = sums_reg[p];
            if (item.bits[p] && s != SUM_MAX) begin
                s = s + CNT_W'(1);
            end
            if (item.use_old && item.old_bits[p] && s != '0) begin
                s = s - CNT_W'(1);
            end
            sums_upd[p] = s;
            if (item.full && s < best_upd) begin
                best_upd = s;
            end
        end
    end

    always_comb begin
        best_next = best_reg;
        for (int p = 0; p < PHASES; p++) begin
            sums_next[p] = sums_reg[p];
        end
        if (proc) begin
            if (item.last) begin
                best_next = SUM_MAX;
                for (int p = 0; p < PHASES; p++) begin
                    sums_next[p] = '0;
                end
            end else begin
                best_next = best_upd;
                for (int p = 0; p < PHASES; p++) begin
                    sums_next[p] = sums_upd[p];
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (proc && item.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg    <= SUM_MAX;
            m_valid_reg <= 1'b0;
            for (int p = 0; p < PHASES; p++) begin
                sums_reg[p] <= '0;
            end
        end else begin
            best_reg    <= best_next;
            m_valid_reg <= m_valid_next;
            for (int p = 0; p < PHASES; p++) begin
                sums_reg[p] <= sums_next[p];
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (proc && item.last) begin
            m_min_reg   <= item.full ? best_upd : '0;
            m_short_reg <= !item.full;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_min   = m_min_reg;
    assign m_short = m_short_reg;

`ifndef SYNTHESIS
    // a short string always reports zero changes
    a_short_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_short_reg |-> m_min_reg == '0)
        else $error("short string with nonzero minimum");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(proc && item.last))
        else $error("result overwritten while stalled");

    // string state is fresh after a result is produced
    a_fresh_best: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && item.last |=> best_reg == SUM_MAX)
        else $error("running minimum not cleared");
`endif

endmodule
